/* rtl/core/plds_pkg.sv */
// Shared types, character codes and result helpers for the literal string decoder.
package plds_pkg;

  localparam int unsigned NEST_LIMIT_DEF = 255;
  localparam int unsigned QDEPTH         = 4;

  localparam logic [7:0] CH_LPAREN = 8'h28;
  localparam logic [7:0] CH_RPAREN = 8'h29;
  localparam logic [7:0] CH_BSLASH = 8'h5C;
  localparam logic [7:0] CH_CR     = 8'h0D;
  localparam logic [7:0] CH_LF     = 8'h0A;
  localparam logic [7:0] CH_TAB    = 8'h09;
  localparam logic [7:0] CH_BS     = 8'h08;
  localparam logic [7:0] CH_FF     = 8'h0C;
  localparam logic [7:0] CH_N      = 8'h6E;
  localparam logic [7:0] CH_R      = 8'h72;
  localparam logic [7:0] CH_T      = 8'h74;
  localparam logic [7:0] CH_B      = 8'h62;
  localparam logic [7:0] CH_F      = 8'h66;
  localparam logic [7:0] CH_0      = 8'h30;
  localparam logic [7:0] CH_7      = 8'h37;

  localparam logic KIND_DATA = 1'b0;
  localparam logic KIND_END  = 1'b1;

  typedef enum logic [2:0] {
    ST_CONTENT  = 3'd0,
    ST_CLOSED   = 3'd1,
    ST_UNTERM   = 3'd2,
    ST_NOOPEN   = 3'd3,
    ST_OVERFLOW = 3'd4
  } status_t;

  typedef struct packed {
    logic [7:0] out_byte;
    logic       has_byte;
    logic       last;
    status_t    status;
  } result_t;

  // one classified input item: one or two results
  typedef struct packed {
    logic    two;
    result_t r0;
    result_t r1;
  } entry_t;

  function automatic result_t mk_byte(logic [7:0] b);
    result_t r;
    r.out_byte = b;
    r.has_byte = 1'b1;
    r.last     = 1'b0;
    r.status   = ST_CONTENT;
    return r;
  endfunction

  function automatic result_t mk_end(status_t s);
    result_t r;
    r.out_byte = 8'h00;
    r.has_byte = 1'b0;
    r.last     = 1'b1;
    r.status   = s;
    return r;
  endfunction

endpackage

/* rtl/core/plds_channels.sv */
// Valid/ready channel interfaces for the decoder input and result streams.
interface plds_in_if;
  logic       valid;
  logic       ready;
  logic       kind;
  logic [7:0] data_byte;

  modport source (output valid, output kind, output data_byte, input ready);
  modport sink   (input valid, input kind, input data_byte, output ready);
endinterface

interface plds_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] out_byte;
  logic       has_byte;
  logic       last;
  logic [2:0] status;

  modport source (output valid, output out_byte, output has_byte, output last,
                  output status, input ready);
  modport sink   (input valid, input out_byte, input has_byte, input last,
                  input status, output ready);
endinterface

/* rtl/core/pdf_literal_string_decoder.sv */
// Top level of the literal string decoder: front, entry queue and back.
//
//  channel  dir  handshake      payload
//  in_ch    in   valid/ready    kind, data_byte
//  out_ch   out  valid/ready    out_byte, has_byte, last, status
//
// One input beat per cycle while the queue has room; the front state
// machine settles each byte combinationally and writes its one or two
// results into a 4-entry queue. The back sends one result per cycle from
// its output register while out_ch is ready, so an item with two results
// goes out as two beats; the queue absorbs that and output stalls.
// Synchronous active-low reset returns to idle and empties the queue.
module pdf_literal_string_decoder import plds_pkg::*; #(
  parameter int unsigned NEST_LIMIT = NEST_LIMIT_DEF
) (
  input  logic       clk,
  input  logic       rst_n,
  plds_in_if.sink    in_ch,
  plds_out_if.source out_ch
);

  logic   push, q_ready, pop, q_valid;
  entry_t push_entry, head;

  // byte classification and nesting/escape state
  plds_front #(.NEST_LIMIT(NEST_LIMIT)) u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_ch      (in_ch),
    .q_ready    (q_ready),
    .push       (push),
    .push_entry (push_entry)
  );

  // decouples byte intake from result delivery
  plds_queue u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (push),
    .push_entry (push_entry),
    .q_ready    (q_ready),
    .pop        (pop),
    .q_valid    (q_valid),
    .head       (head)
  );

  // splits entries into result beats
  plds_back u_back (
    .clk     (clk),
    .rst_n   (rst_n),
    .q_valid (q_valid),
    .head    (head),
    .pop     (pop),
    .out_ch  (out_ch)
  );

endmodule

/* rtl/core/plds_front.sv */
// Front end: takes input beats, runs the unescape state machine, emits entries.
module plds_front import plds_pkg::*; #(
  parameter int unsigned NEST_LIMIT = NEST_LIMIT_DEF
) (
  input  logic          clk,
  input  logic          rst_n,
  plds_in_if.sink       in_ch,
  input  logic          q_ready,
  output logic          push,
  output entry_t        push_entry
);

  localparam int unsigned DEPTH_W = $clog2(NEST_LIMIT + 1);
  localparam logic [DEPTH_W-1:0] LIMIT = DEPTH_W'(NEST_LIMIT);

  typedef enum logic [3:0] {
    M_IDLE = 4'b0001,
    M_BODY = 4'b0010,
    M_ESC  = 4'b0100,
    M_OCT  = 4'b1000
  } mode_t;

  mode_t              mode_r, mode_nxt;
  logic [7:0]         oval_r, oval_nxt;
  logic [1:0]         ocnt_r, ocnt_nxt;
  logic               swallow_r, swallow_nxt;
  logic [DEPTH_W-1:0] depth_r, depth_nxt;

  logic               in_fire;
  logic [1:0]         nres;
  result_t            res [2];
  logic               do_body;
  logic [7:0]         c;
  logic [DEPTH_W-1:0] dec_depth;

  assign in_ch.ready = q_ready;
  assign in_fire     = in_ch.valid && q_ready;
  assign c           = in_ch.data_byte;
  assign dec_depth   = depth_r - DEPTH_W'(depth_r != '0);

  always_comb begin
    mode_nxt    = mode_r;
    oval_nxt    = oval_r;
    ocnt_nxt    = ocnt_r;
    swallow_nxt = swallow_r;
    depth_nxt   = depth_r;
    nres        = 2'd0;
    res[0]      = mk_end(ST_CONTENT);
    res[1]      = mk_end(ST_CONTENT);
    do_body     = 1'b0;

    if (in_ch.kind == KIND_END) begin
      if (mode_r == M_IDLE) begin
        res[0] = mk_end(ST_NOOPEN);
        nres   = 2'd1;
      end else begin
        if (mode_r == M_OCT) begin
          res[0] = mk_byte(oval_r);
          nres   = 2'd1;
        end
        res[nres[0]] = mk_end(ST_UNTERM);
        nres         = nres + 2'd1;
      end
      mode_nxt    = M_IDLE;
      oval_nxt    = '0;
      ocnt_nxt    = '0;
      swallow_nxt = 1'b0;
      depth_nxt   = '0;
    end else if (mode_r == M_IDLE) begin
      if (c == CH_LPAREN) begin
        mode_nxt    = M_BODY;
        depth_nxt   = DEPTH_W'(1);
        oval_nxt    = '0;
        ocnt_nxt    = '0;
        swallow_nxt = 1'b0;
      end else begin
        res[0] = mk_end(ST_NOOPEN);
        nres   = 2'd1;
      end
    end else if (swallow_r && c == CH_LF) begin
      swallow_nxt = 1'b0;  // LF after CR is dropped
    end else begin
      swallow_nxt = 1'b0;
      case (mode_r)
        M_ESC: begin
          mode_nxt = M_BODY;
          case (c)
            CH_N:  begin res[0] = mk_byte(CH_LF);  nres = 2'd1; end
            CH_R:  begin res[0] = mk_byte(CH_CR);  nres = 2'd1; end
            CH_T:  begin res[0] = mk_byte(CH_TAB); nres = 2'd1; end
            CH_B:  begin res[0] = mk_byte(CH_BS);  nres = 2'd1; end
            CH_F:  begin res[0] = mk_byte(CH_FF);  nres = 2'd1; end
            CH_CR: swallow_nxt = 1'b1;
            CH_LF: ;
            default: begin
              if (c inside {[CH_0:CH_7]}) begin
                mode_nxt = M_OCT;
                oval_nxt = {5'd0, c[2:0]};
                ocnt_nxt = 2'd1;
              end else begin
                res[0] = mk_byte(c);
                nres   = 2'd1;
              end
            end
          endcase
        end
        M_OCT: begin
          if (c inside {[CH_0:CH_7]}) begin
            oval_nxt = {oval_r[4:0], c[2:0]};
            if (ocnt_r == 2'd2) begin
              res[0]   = mk_byte({oval_r[4:0], c[2:0]});
              nres     = 2'd1;
              mode_nxt = M_BODY;
              oval_nxt = '0;
              ocnt_nxt = '0;
            end else begin
              ocnt_nxt = ocnt_r + 2'd1;
            end
          end else begin
            res[0]   = mk_byte(oval_r);
            nres     = 2'd1;
            mode_nxt = M_BODY;
            oval_nxt = '0;
            ocnt_nxt = '0;
            do_body  = 1'b1;
          end
        end
        default: do_body = 1'b1;
      endcase

      if (do_body) begin
        case (c)
          CH_BSLASH: mode_nxt = M_ESC;
          CH_LPAREN: begin
            if (depth_r == LIMIT) begin
              res[nres[0]] = mk_end(ST_OVERFLOW);
              mode_nxt     = M_IDLE;
              oval_nxt     = '0;
              ocnt_nxt     = '0;
              swallow_nxt  = 1'b0;
              depth_nxt    = '0;
            end else begin
              depth_nxt    = depth_r + DEPTH_W'(1);
              res[nres[0]] = mk_byte(c);
            end
            nres = nres + 2'd1;
          end
          CH_RPAREN: begin
            if (dec_depth == '0) begin
              res[nres[0]] = mk_end(ST_CLOSED);
              mode_nxt     = M_IDLE;
              oval_nxt     = '0;
              ocnt_nxt     = '0;
              swallow_nxt  = 1'b0;
              depth_nxt    = '0;
            end else begin
              depth_nxt    = dec_depth;
              res[nres[0]] = mk_byte(c);
            end
            nres = nres + 2'd1;
          end
          CH_CR: begin
            res[nres[0]] = mk_byte(CH_LF);
            nres         = nres + 2'd1;
            swallow_nxt  = 1'b1;
          end
          default: begin
            res[nres[0]] = mk_byte(c);
            nres         = nres + 2'd1;
          end
        endcase
      end
    end
  end

  assign push          = in_fire && (nres != 2'd0);
  assign push_entry.two = nres[1];
  assign push_entry.r0  = res[0];
  assign push_entry.r1  = res[1];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r    <= M_IDLE;
      oval_r    <= '0;
      ocnt_r    <= '0;
      swallow_r <= 1'b0;
      depth_r   <= '0;
    end else if (in_fire) begin
      mode_r    <= mode_nxt;
      oval_r    <= oval_nxt;
      ocnt_r    <= ocnt_nxt;
      swallow_r <= swallow_nxt;
      depth_r   <= depth_nxt;
    end
  end

  a_idle_depth: assert property (@(posedge clk) disable iff (!rst_n)
    mode_r == M_IDLE |-> depth_r == '0)
    else $error("depth nonzero while idle");

  a_last_goes_idle: assert property (@(posedge clk) disable iff (!rst_n)
    push && (push_entry.two ? push_entry.r1.last : push_entry.r0.last)
    |=> mode_r == M_IDLE)
    else $error("string ended but not idle");

endmodule

/* rtl/core/plds_queue.sv */
// Short FIFO of classified entries between front and back.
module plds_queue import plds_pkg::*; (
  input  logic   clk,
  input  logic   rst_n,
  input  logic   push,
  input  entry_t push_entry,
  output logic   q_ready,
  input  logic   pop,
  output logic   q_valid,
  output entry_t head
);

  localparam int unsigned PTR_W = $clog2(QDEPTH);
  localparam logic [PTR_W:0] FULL = (PTR_W + 1)'(QDEPTH);

  entry_t         mem_r [QDEPTH];
  logic [PTR_W-1:0] wr_r, rd_r;
  logic [PTR_W:0]   cnt_r;
  logic             do_push, do_pop;

  assign q_ready = cnt_r != FULL;
  assign q_valid = cnt_r != '0;
  assign head    = mem_r[rd_r];
  assign do_push = push && q_ready;
  assign do_pop  = pop && q_valid;

  always_ff @(posedge clk) begin
    if (do_push) mem_r[wr_r] <= push_entry;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_r  <= '0;
      rd_r  <= '0;
      cnt_r <= '0;
    end else begin
      if (do_push) wr_r <= wr_r + PTR_W'(1);
      if (do_pop)  rd_r <= rd_r + PTR_W'(1);
      cnt_r <= cnt_r + (PTR_W + 1)'(do_push) - (PTR_W + 1)'(do_pop);
    end
  end

  a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= FULL)
    else $error("queue count out of range");

endmodule

/* rtl/core/plds_back.sv */
// Back end: unpacks entries into single result beats behind an output register.
module plds_back import plds_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      q_valid,
  input  entry_t    head,
  output logic      pop,
  plds_out_if.source out_ch
);

  logic    out_valid_r;
  result_t out_r;
  logic    pend_r;
  result_t pend_res_r;
  logic    free;

  assign free = !out_valid_r || out_ch.ready;
  assign pop  = free && !pend_r && q_valid;

  assign out_ch.valid    = out_valid_r;
  assign out_ch.out_byte = out_r.out_byte;
  assign out_ch.has_byte = out_r.has_byte;
  assign out_ch.last     = out_r.last;
  assign out_ch.status   = out_r.status;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
      pend_r      <= 1'b0;
    end else if (free) begin
      if (pend_r) begin
        out_valid_r <= 1'b1;
        pend_r      <= 1'b0;
      end else begin
        out_valid_r <= q_valid;
        pend_r      <= q_valid && head.two;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (free) begin
      if (pend_r) begin
        out_r <= pend_res_r;
      end else if (q_valid) begin
        out_r      <= head.r0;
        pend_res_r <= head.r1;
      end
    end
  end

  a_pend_has_out: assert property (@(posedge clk) disable iff (!rst_n)
    pend_r |-> out_valid_r)
    else $error("second result pending without a first");

endmodule
